@@ rtl/slik_pkg.sv @@
// ----------------------------------------------------------------------------
// Stewart leg length package
// Shared widths, anchor coordinates, register codes and the control bundle
// that the back end hands to its leg lanes.
// ----------------------------------------------------------------------------
package slik_pkg;

  // Default number of fraction bits of the rotation arithmetic.
  localparam int ROT_FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int TRIG_W   = 15;
  localparam int TRANS_W  = 25;
  localparam int HOME_W   = 12;
  localparam int LEG_W    = 20;
  localparam int NUM_LEGS = 6;
  localparam int ANCHOR_W = 25;

  // Internal widths: leg vector component, sum of squares, root.
  localparam int LEN_W  = 30;
  localparam int SQ_W   = 60;
  localparam int ROOT_W = 30;
  localparam int HOFF_W = 26;

  // Square root retires two result bits a cycle.
  localparam int ROOT_STEPS = SQ_W / 4;

  localparam logic [LEG_W-1:0]  LEG_MAX    = 20'd600000;
  localparam logic [HOME_W-1:0] HOME_RESET = 12'd1600;
  localparam int                SCALE      = 10000;

  // Items that may wait between the front and the back end.
  localparam int QUEUE_DEPTH = 8;

  // Anchor coordinates in units of 0.0001 mm.
  localparam logic signed [ANCHOR_W-1:0] PLAT_X [NUM_LEGS] = '{
    25'sd4914635, 25'sd4914635, 25'sd3009379,
    -25'sd7924014, -25'sd7924014, 25'sd3009379};
  localparam logic signed [ANCHOR_W-1:0] PLAT_Y [NUM_LEGS] = '{
    -25'sd6312398, 25'sd6312398, 25'sd7412398,
    25'sd1100000, -25'sd1100000, -25'sd7412398};
  localparam logic signed [ANCHOR_W-1:0] BASE_X [NUM_LEGS] = '{
    25'sd9901515, 25'sd9901515, -25'sd3738322,
    -25'sd6163193, -25'sd6163193, -25'sd3738322};
  localparam logic signed [ANCHOR_W-1:0] BASE_Y [NUM_LEGS] = '{
    -25'sd1400000, 25'sd1400000, 25'sd9274964,
    25'sd7874964, -25'sd7874964, -25'sd9274964};

  // Configuration register index.
  typedef enum logic [0:0] {
    REG_HOME_HEIGHT = 1'b0
  } reg_idx_e;

  // Step strobes from the back-end sequencer to every lane.
  typedef struct packed {
    logic            mul;
    logic            sum;
    logic            sqr;
    logic            acc;
    logic            root;
    logic            scale;
    logic            div;
    logic [SQ_W-1:0] root_bit;
  } lane_ctrl_t;

endpackage

@@ rtl/slik_front.sv @@
// ----------------------------------------------------------------------------
// Stewart leg length front end
// Accepts a pose every cycle, converts the trigonometric values to fixed
// point and builds the six used entries of the rotation matrix in a
// five-stage pipeline.
// ----------------------------------------------------------------------------
module slik_front #(
  parameter int ROT_FRAC_BITS = slik_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  cos_x_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  cos_y_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  cos_z_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  sin_x_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  sin_y_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  sin_z_i,
  input  logic signed [slik_pkg::TRANS_W-1:0] trans_x_i,
  input  logic signed [slik_pkg::TRANS_W-1:0] trans_y_i,
  input  logic signed [slik_pkg::TRANS_W-1:0] trans_z_i,
  output logic                                valid_o,
  output logic [6*(ROT_FRAC_BITS+5)+3*slik_pkg::TRANS_W-1:0] pose_o,
  output logic [2:0]                          inflight_o
);
  import slik_pkg::*;

  localparam int F      = ROT_FRAC_BITS;
  localparam int RW     = F + 5;
  localparam int STAGES = 5;
  localparam int NTRIG  = 6;
  // v * 2^F / 10000 = v * 2^(F-4) / 625, split into quotient and remainder.
  localparam longint D_SCALED = longint'(1) << (F - 4);
  localparam longint QD       = D_SCALED / 625;
  localparam longint RD       = D_SCALED % 625;
  localparam longint XBIAS    = 312 + 625 * 16384;
  localparam longint RECIP625 = 64'd3518437209;   // ceil(2^41 / 625)
  localparam longint HALF     = longint'(1) << (F - 1);

  // Trig index order: cx, cy, cz, sx, sy, sz.
  localparam int CX = 0;
  localparam int CY = 1;
  localparam int CZ = 2;
  localparam int SX = 3;
  localparam int SY = 4;
  localparam int SZ = 5;

  function automatic logic signed [RW-1:0] qmul(input logic signed [RW-1:0] a,
                                                input logic signed [RW-1:0] b);
    logic signed [2*RW-1:0] p;
    p = (2*RW)'(a) * (2*RW)'(b) + (2*RW)'(HALF);
    return RW'(p >>> F);
  endfunction

  logic signed [TRIG_W-1:0] trig [NTRIG];
  logic [STAGES-1:0]        v_q;

  logic signed [RW-1:0] hi1_q [NTRIG];
  logic [24:0]          xb1_q [NTRIG];
  logic signed [RW-1:0] c2_q  [NTRIG];

  logic signed [RW-1:0] czcy3_q, szcx3_q, czsy3_q, szcy3_q, czcx3_q, szsy3_q;
  logic signed [RW-1:0] cysx3_q, sx3_q, sy3_q;
  logic signed [RW-1:0] czcy4_q, szcx4_q, szcy4_q, czcx4_q, cysx4_q, sy4_q;
  logic signed [RW-1:0] czsysx4_q, szsysx4_q;
  logic signed [RW-1:0] r00_q, r01_q, r10_q, r11_q, r20_q, r21_q;

  logic signed [TRANS_W-1:0] tx_q [STAGES];
  logic signed [TRANS_W-1:0] ty_q [STAGES];
  logic signed [TRANS_W-1:0] tz_q [STAGES];

  assign trig[CX] = cos_x_i;
  assign trig[CY] = cos_y_i;
  assign trig[CZ] = cos_z_i;
  assign trig[SX] = sin_x_i;
  assign trig[SY] = sin_y_i;
  assign trig[SZ] = sin_z_i;

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  // Translation travels alongside the rotation work.
  always_ff @(posedge clk_i) begin
    tx_q[0] <= trans_x_i;
    ty_q[0] <= trans_y_i;
    tz_q[0] <= trans_z_i;
    for (int s = 1; s < STAGES; s++) begin
      tx_q[s] <= tx_q[s-1];
      ty_q[s] <= ty_q[s-1];
      tz_q[s] <= tz_q[s-1];
    end
  end

  // Stages one and two: scaling by 2^F / 10000 with rounding to nearest.
  for (genvar k = 0; k < NTRIG; k++) begin : g_conv
    logic signed [27:0]   x_w;
    logic [56:0]          prod_w;
    logic [15:0]          qlo_w;

    always_comb begin
      x_w    = 28'(trig[k]) * 28'(RD) + 28'(XBIAS);
      prod_w = 57'(xb1_q[k]) * 57'(RECIP625);
      qlo_w  = prod_w[56:41];
    end

    always_ff @(posedge clk_i) begin
      hi1_q[k] <= RW'(trig[k]) * RW'(QD);
      xb1_q[k] <= x_w[24:0];
      c2_q[k]  <= hi1_q[k] + RW'(qlo_w) - RW'(16384);
    end
  end

  // Stage three: first level of products.
  always_ff @(posedge clk_i) begin
    czcy3_q <= qmul(c2_q[CZ], c2_q[CY]);
    szcx3_q <= qmul(c2_q[SZ], c2_q[CX]);
    czsy3_q <= qmul(c2_q[CZ], c2_q[SY]);
    szcy3_q <= qmul(c2_q[SZ], c2_q[CY]);
    czcx3_q <= qmul(c2_q[CZ], c2_q[CX]);
    szsy3_q <= qmul(c2_q[SZ], c2_q[SY]);
    cysx3_q <= qmul(c2_q[CY], c2_q[SX]);
    sx3_q   <= c2_q[SX];
    sy3_q   <= c2_q[SY];
  end

  // Stage four: products that take a rounded product as operand.
  always_ff @(posedge clk_i) begin
    czsysx4_q <= qmul(czsy3_q, sx3_q);
    szsysx4_q <= qmul(szsy3_q, sx3_q);
    czcy4_q   <= czcy3_q;
    szcx4_q   <= szcx3_q;
    szcy4_q   <= szcy3_q;
    czcx4_q   <= czcx3_q;
    cysx4_q   <= cysx3_q;
    sy4_q     <= sy3_q;
  end

  // Stage five: matrix entries.
  always_ff @(posedge clk_i) begin
    r00_q <= czcy4_q;
    r01_q <= czsysx4_q - szcx4_q;
    r10_q <= szcy4_q;
    r11_q <= czcx4_q + szsysx4_q;
    r20_q <= -sy4_q;
    r21_q <= cysx4_q;
  end

  assign valid_o    = v_q[STAGES-1];
  assign pose_o     = {r00_q, r01_q, r10_q, r11_q, r20_q, r21_q,
                       tx_q[STAGES-1], ty_q[STAGES-1], tz_q[STAGES-1]};
  assign inflight_o = 3'($countones(v_q));

endmodule

@@ rtl/slik_queue.sv @@
// ----------------------------------------------------------------------------
// Stewart leg length item queue
// A small first-in first-out store of poses between the front and the back
// end.
// ----------------------------------------------------------------------------
module slik_queue #(
  parameter int WIDTH = 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  logic [WIDTH-1:0]                       data_i,
  input  logic                                   pop_i,
  output logic [WIDTH-1:0]                       data_o,
  output logic                                   empty_o,
  output logic [$clog2(slik_pkg::QUEUE_DEPTH+1)-1:0] count_o
);
  import slik_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  // The busy logic must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < CNT_W'(QUEUE_DEPTH)) || pop_i)
    else $error("item pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("item popped from an empty queue");

endmodule

@@ rtl/slik_lane.sv @@
// ----------------------------------------------------------------------------
// Stewart leg length lane
// Datapath of one leg: rotated anchor, leg vector, sum of squares, square
// root and scaling to hundredths of a millimetre.
// ----------------------------------------------------------------------------
module slik_lane #(
  parameter int ROT_FRAC_BITS = slik_pkg::ROT_FRAC_BITS_DEF,
  parameter int LEG           = 0
) (
  input  logic                                 clk_i,
  input  slik_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [ROT_FRAC_BITS+4:0]      r00_i,
  input  logic signed [ROT_FRAC_BITS+4:0]      r01_i,
  input  logic signed [ROT_FRAC_BITS+4:0]      r10_i,
  input  logic signed [ROT_FRAC_BITS+4:0]      r11_i,
  input  logic signed [ROT_FRAC_BITS+4:0]      r20_i,
  input  logic signed [ROT_FRAC_BITS+4:0]      r21_i,
  input  logic signed [slik_pkg::TRANS_W-1:0]  tx_i,
  input  logic signed [slik_pkg::TRANS_W-1:0]  ty_i,
  input  logic signed [slik_pkg::TRANS_W-1:0]  tz_i,
  input  logic [slik_pkg::HOFF_W-1:0]          hoff_i,
  output logic [slik_pkg::LEG_W-1:0]           len_o
);
  import slik_pkg::*;

  localparam int     F       = ROT_FRAC_BITS;
  localparam int     RW      = F + 5;
  localparam int     PW      = RW + ANCHOR_W;
  localparam longint HALF    = longint'(1) << (F - 1);
  localparam longint RECIP25 = 64'd1374389535;   // ceil(2^35 / 25)
  localparam int     Z_W     = ROOT_W - 1;

  logic signed [PW-1:0]    ax_q, bx_q, ay_q, by_q, az_q, bz_q;
  logic signed [LEN_W-1:0] lx_q, ly_q, lz_q;
  logic [SQ_W-1:0]         sqx_q, sqy_q, sqz_q;
  logic [SQ_W-1:0]         s_q, res_q;
  logic [Z_W-1:0]          z_q;
  logic [LEG_W-1:0]        len_q;

  logic signed [PW:0]      sx_w, sy_w, sz_w;
  logic signed [PW:0]      rx_w, ry_w, rz_w;
  logic [LEN_W-1:0]        mx_w, my_w, mz_w;
  logic [SQ_W-1:0]         b1_w, b2_w, s1_w, r1_w, s2_w, r2_w;
  logic [ROOT_W:0]         t_w;
  logic [Z_W+31-1:0]       dprod_w;
  logic [Z_W+31-36:0]      q_w;

  // Rotated anchor, rounded to whole units, plus offsets.
  always_comb begin
    sx_w = (PW+1)'(ax_q) + (PW+1)'(bx_q) + (PW+1)'(HALF);
    sy_w = (PW+1)'(ay_q) + (PW+1)'(by_q) + (PW+1)'(HALF);
    sz_w = (PW+1)'(az_q) + (PW+1)'(bz_q) + (PW+1)'(HALF);
    rx_w = sx_w >>> F;
    ry_w = sy_w >>> F;
    rz_w = sz_w >>> F;
  end

  // Magnitudes for squaring.
  always_comb begin
    mx_w = lx_q[LEN_W-1] ? LEN_W'(-lx_q) : LEN_W'(lx_q);
    my_w = ly_q[LEN_W-1] ? LEN_W'(-ly_q) : LEN_W'(ly_q);
    mz_w = lz_q[LEN_W-1] ? LEN_W'(-lz_q) : LEN_W'(lz_q);
  end

  // Two digit-by-digit square root steps.
  always_comb begin
    b1_w = ctrl_i.root_bit;
    b2_w = ctrl_i.root_bit >> 2;
    if (s_q >= res_q + b1_w) begin
      s1_w = s_q - (res_q + b1_w);
      r1_w = (res_q >> 1) + b1_w;
    end else begin
      s1_w = s_q;
      r1_w = res_q >> 1;
    end
    if (s1_w >= r1_w + b2_w) begin
      s2_w = s1_w - (r1_w + b2_w);
      r2_w = (r1_w >> 1) + b2_w;
    end else begin
      s2_w = s1_w;
      r2_w = r1_w >> 1;
    end
  end

  // Rounding to hundredths: (root + 50) / 4, then / 25 by reciprocal.
  always_comb begin
    t_w     = (ROOT_W+1)'(res_q[ROOT_W-1:0]) + (ROOT_W+1)'(50);
    dprod_w = (Z_W+31)'(z_q) * (Z_W+31)'(RECIP25);
    q_w     = dprod_w[Z_W+31-1:35];
  end

  // Step registers, loaded under control of the sequencer.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      ax_q <= PW'(r00_i) * PW'(PLAT_X[LEG]);
      bx_q <= PW'(r01_i) * PW'(PLAT_Y[LEG]);
      ay_q <= PW'(r10_i) * PW'(PLAT_X[LEG]);
      by_q <= PW'(r11_i) * PW'(PLAT_Y[LEG]);
      az_q <= PW'(r20_i) * PW'(PLAT_X[LEG]);
      bz_q <= PW'(r21_i) * PW'(PLAT_Y[LEG]);
    end
    if (ctrl_i.sum) begin
      lx_q <= LEN_W'(rx_w) + LEN_W'(tx_i) - LEN_W'(BASE_X[LEG]);
      ly_q <= LEN_W'(ry_w) + LEN_W'(ty_i) - LEN_W'(BASE_Y[LEG]);
      lz_q <= LEN_W'(rz_w) + LEN_W'(tz_i) + LEN_W'(hoff_i);
    end
    if (ctrl_i.sqr) begin
      sqx_q <= SQ_W'(mx_w) * SQ_W'(mx_w);
      sqy_q <= SQ_W'(my_w) * SQ_W'(my_w);
      sqz_q <= SQ_W'(mz_w) * SQ_W'(mz_w);
    end
    if (ctrl_i.acc) begin
      s_q   <= sqx_q + sqy_q + sqz_q;
      res_q <= '0;
    end else if (ctrl_i.root) begin
      s_q   <= s2_w;
      res_q <= r2_w;
    end
    if (ctrl_i.scale) begin
      z_q <= t_w[ROOT_W:2];
    end
    if (ctrl_i.div) begin
      len_q <= (q_w > (Z_W+31-35)'(LEG_MAX)) ? LEG_MAX : q_w[LEG_W-1:0];
    end
  end

  assign len_o = len_q;

endmodule

@@ rtl/slik_back.sv @@
// ----------------------------------------------------------------------------
// Stewart leg length back end
// Takes poses from the queue and steps six leg lanes through product, sum,
// square, root and scaling, then strobes the six lengths out.
// ----------------------------------------------------------------------------
module slik_back #(
  parameter int ROT_FRAC_BITS = slik_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  logic [6*(ROT_FRAC_BITS+5)+3*slik_pkg::TRANS_W-1:0] pose_i,
  output logic                               pop_o,
  input  logic [slik_pkg::HOME_W-1:0]        home_i,
  output logic                               done_o,
  output logic [slik_pkg::LEG_W-1:0]         len_o [slik_pkg::NUM_LEGS]
);
  import slik_pkg::*;

  localparam int RW    = ROT_FRAC_BITS + 5;
  localparam int CNT_W = $clog2(ROOT_STEPS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SUM   = 7'b0000010,
    ST_SQR   = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_ROOT  = 7'b0010000,
    ST_SCALE = 7'b0100000,
    ST_DIV   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SQ_W-1:0]  bit_q, bit_d;
  logic             done_q, done_d;
  lane_ctrl_t       ctrl;

  logic signed [RW-1:0]      r00, r01, r10, r11, r20, r21;
  logic signed [TRANS_W-1:0] tx, ty, tz;
  logic signed [TRANS_W-1:0] tx_q, ty_q, tz_q;
  logic [HOFF_W-1:0]         hoff_q;

  // Unpack the queue head.
  assign {r00, r01, r10, r11, r20, r21, tx, ty, tz} = pose_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    ctrl    = '0;
    ctrl.root_bit = bit_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          ctrl.mul = 1'b1;
          state_d  = ST_SUM;
        end
      end
      ST_SUM: begin
        ctrl.sum = 1'b1;
        state_d  = ST_SQR;
      end
      ST_SQR: begin
        ctrl.sqr = 1'b1;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        ctrl.acc = 1'b1;
        bit_d    = SQ_W'(1) << (SQ_W - 2);
        cnt_d    = '0;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        ctrl.root = 1'b1;
        bit_d     = bit_q >> 4;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        ctrl.scale = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div = 1'b1;
        done_d   = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Root bit and the translation of the item at work.
  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
    if (pop_o) begin
      tx_q   <= tx;
      ty_q   <= ty;
      tz_q   <= tz;
      hoff_q <= HOFF_W'(home_i) * HOFF_W'(SCALE);
    end
  end

  // One lane per leg.
  for (genvar g = 0; g < NUM_LEGS; g++) begin : g_lane
    slik_lane #(
      .ROT_FRAC_BITS(ROT_FRAC_BITS),
      .LEG          (g)
    ) u_lane (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .r00_i (r00),
      .r01_i (r01),
      .r10_i (r10),
      .r11_i (r11),
      .r20_i (r20),
      .r21_i (r21),
      .tx_i  (tx_q),
      .ty_i  (ty_q),
      .tz_i  (tz_q),
      .hoff_i(hoff_q),
      .len_o (len_o[g])
    );
  end

  assign done_o = done_q;

  // A result follows a full pass of the sequencer, never two in a row.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("two results in consecutive cycles");

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (len_o[0] <= LEG_MAX) && (len_o[1] <= LEG_MAX) &&
               (len_o[2] <= LEG_MAX) && (len_o[3] <= LEG_MAX) &&
               (len_o[4] <= LEG_MAX) && (len_o[5] <= LEG_MAX))
    else $error("leg length above saturation limit");

endmodule

@@ rtl/stewart_leg_length_ik.sv @@
// ----------------------------------------------------------------------------
// Stewart platform leg lengths
// Inverse kinematics of a six-leg platform: one pose in, six leg lengths out.
// ----------------------------------------------------------------------------
// A pose is taken whenever start is high and busy is low. The front end
// turns it into a rotation matrix in its pipeline and parks it in an
// eight-item queue; the back end then works on one item at a time and takes
// the next only once it has finished the current one, its pace set by the
// digit-by-digit square root that retires two result bits a cycle in all six
// leg lanes at once. Results are shown for exactly one cycle under done_o and
// cannot be held off, so the receiver must take them as they come.
// busy rises while the queue and the front pipeline together hold eight
// items. home_height sits at byte address 0 and may be written only while
// no item is in flight.
// ----------------------------------------------------------------------------
module stewart_leg_length_ik #(
  parameter int ROT_FRAC_BITS = slik_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [slik_pkg::TRIG_W-1:0]  cos_x_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  cos_y_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  cos_z_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  sin_x_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  sin_y_i,
  input  logic signed [slik_pkg::TRIG_W-1:0]  sin_z_i,
  input  logic signed [slik_pkg::TRANS_W-1:0] trans_x_i,
  input  logic signed [slik_pkg::TRANS_W-1:0] trans_y_i,
  input  logic signed [slik_pkg::TRANS_W-1:0] trans_z_i,
  output logic                                done_o,
  output logic [slik_pkg::LEG_W-1:0]          leg_length_1_o,
  output logic [slik_pkg::LEG_W-1:0]          leg_length_2_o,
  output logic [slik_pkg::LEG_W-1:0]          leg_length_3_o,
  output logic [slik_pkg::LEG_W-1:0]          leg_length_4_o,
  output logic [slik_pkg::LEG_W-1:0]          leg_length_5_o,
  output logic [slik_pkg::LEG_W-1:0]          leg_length_6_o
);
  import slik_pkg::*;

  localparam int POSE_W = 6 * (ROT_FRAC_BITS + 5) + 3 * TRANS_W;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W  = CNT_W + 1;

  logic [HOME_W-1:0] home_q;
  logic              wr_en;
  logic              accept;
  logic              f_valid;
  logic [POSE_W-1:0] f_pose, q_pose;
  logic [2:0]        inflight;
  logic              q_empty, q_pop;
  logic [CNT_W-1:0]  q_count;
  logic [OCC_W-1:0]  occupancy;
  logic [LEG_W-1:0]  len [NUM_LEGS];

  // Configuration register.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HOME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q <= HOME_RESET;
    end else if (wr_en) begin
      home_q <= pwdata[HOME_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_HOME_HEIGHT) ? 32'(home_q) : '0;

  // Admission: the queue must have room for everything in flight.
  assign occupancy = OCC_W'(q_count) + OCC_W'(inflight);
  assign busy      = (occupancy >= OCC_W'(QUEUE_DEPTH));
  assign accept    = start && !busy;

  slik_front #(
    .ROT_FRAC_BITS(ROT_FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .cos_x_i   (cos_x_i),
    .cos_y_i   (cos_y_i),
    .cos_z_i   (cos_z_i),
    .sin_x_i   (sin_x_i),
    .sin_y_i   (sin_y_i),
    .sin_z_i   (sin_z_i),
    .trans_x_i (trans_x_i),
    .trans_y_i (trans_y_i),
    .trans_z_i (trans_z_i),
    .valid_o   (f_valid),
    .pose_o    (f_pose),
    .inflight_o(inflight)
  );

  slik_queue #(
    .WIDTH(POSE_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .data_i (f_pose),
    .pop_i  (q_pop),
    .data_o (q_pose),
    .empty_o(q_empty),
    .count_o(q_count)
  );

  slik_back #(
    .ROT_FRAC_BITS(ROT_FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(q_empty),
    .pose_i (q_pose),
    .pop_o  (q_pop),
    .home_i (home_q),
    .done_o (done_o),
    .len_o  (len)
  );

  assign leg_length_1_o = len[0];
  assign leg_length_2_o = len[1];
  assign leg_length_3_o = len[2];
  assign leg_length_4_o = len[3];
  assign leg_length_5_o = len[4];
  assign leg_length_6_o = len[5];

endmodule
